// ----- hw/rtl/assert_macros.svh -----
// Assertion helper macros for the lattice analysis filter checker.
// Stand-alone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/laf_pkg.sv -----
// Shared types and constants of the lattice analysis filter.
// No dependencies.
`default_nettype none

package laf_pkg;

   localparam int MAX_ORDER_DEF = 16;
   localparam int CFG_W         = 5;
   localparam int IDX_W         = 4;
   localparam int COEF_W        = 16;
   localparam int SAMPLE_W      = 16;
   localparam int VAL_W         = 20;
   localparam int FRAC_W        = 15;

   localparam logic [CFG_W-1:0] STAGES_RESET = CFG_W'(16);

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_FILTER = 1'b1;

   typedef struct packed {
      logic                       action;
      logic [IDX_W-1:0]           coef_index;
      logic signed [COEF_W-1:0]   coef_value;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       frame_start;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] forward_error;
      logic signed [VAL_W-1:0] backward_error;
   } rsp_type;

   // operands of one lattice butterfly
   typedef struct packed {
      logic signed [COEF_W-1:0] k;
      logic signed [VAL_W-1:0]  f;
      logic signed [VAL_W-1:0]  bd;
   } stage_in_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] nf;
      logic signed [VAL_W-1:0] nb;
   } stage_out_type;

endpackage

`default_nettype wire

// ----- hw/rtl/laf_stage_unit.sv -----
// Shared lattice butterfly: two Q15 products, rounding, saturating subtracts.
// Depends on laf_pkg.
`default_nettype none

module laf_stage_unit
   import laf_pkg::*;
(
   input  stage_in_type  stage_in,
   output stage_out_type stage_out
);

   localparam int PROD_W = COEF_W + VAL_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int DIFF_W = VAL_W + 3;
   localparam logic signed [SUM_W-1:0] RND = SUM_W'(2 ** (FRAC_W - 1));

   logic signed [PROD_W-1:0] prod_b, prod_f;
   logic signed [SUM_W-1:0]  rnd_b, rnd_f;
   logic signed [DIFF_W-1:0] diff_f, diff_b;

   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [DIFF_W-1:0] x);
      logic ovf;
      ovf = (x[DIFF_W-1:VAL_W-1] != {(DIFF_W-VAL_W+1){1'b0}}) &&
            (x[DIFF_W-1:VAL_W-1] != {(DIFF_W-VAL_W+1){1'b1}});
      if (!ovf) begin
         return x[VAL_W-1:0];
      end else if (x[DIFF_W-1]) begin
         return {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         return {1'b0, {(VAL_W-1){1'b1}}};
      end
   endfunction

   always_comb begin
      prod_b = $signed(stage_in.k) * $signed(stage_in.bd);
      prod_f = $signed(stage_in.k) * $signed(stage_in.f);
      // floor((p + 2^14) / 2^15): round to nearest, ties up
      rnd_b  = (SUM_W'(prod_b) + RND) >>> FRAC_W;
      rnd_f  = (SUM_W'(prod_f) + RND) >>> FRAC_W;
      diff_f = DIFF_W'(stage_in.f)  - DIFF_W'(rnd_b);
      diff_b = DIFF_W'(stage_in.bd) - DIFF_W'(rnd_f);
      stage_out.nf = sat_val(diff_f);
      stage_out.nb = sat_val(diff_b);
   end

endmodule

`default_nettype wire

// ----- hw/rtl/lattice_analysis_filter_top.sv -----
// Lattice FIR analysis filter. A load transaction writes one Q15 reflection
// coefficient and does not block the next transaction. A filter transaction
// runs n = min(stages_in_use, MAX_ORDER) lattice stages before the next is
// accepted: it is accepted, then one lattice stage runs per cycle through the
// single shared butterfly unit. The result sits in an output register, so a
// new transaction is taken while it waits; if that register is still full when
// the last stage finishes, the filter holds until it drains.
// Depends on laf_pkg and laf_stage_unit.
`default_nettype none

module lattice_analysis_filter_top
   import laf_pkg::*;
#(
   parameter int MAX_ORDER = MAX_ORDER_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [CFG_W-1:0]        stages_ff, stages_in;
   logic signed [COEF_W-1:0] coef_ff  [MAX_ORDER];
   logic signed [COEF_W-1:0] coef_in  [MAX_ORDER];
   logic signed [VAL_W-1:0]  delay_ff [MAX_ORDER];
   logic signed [VAL_W-1:0]  delay_in [MAX_ORDER];
   logic signed [VAL_W-1:0]  f_ff, f_in, b_ff, b_in;
   logic [IW-1:0]           stage_ff, stage_in, last_ff, last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   stage_in_type            bfly_in;
   stage_out_type           bfly_out;
   logic                    out_free;
   logic signed [VAL_W-1:0] sample_ext;

   laf_stage_unit u_stage_unit (
      .stage_in  (bfly_in),
      .stage_out (bfly_out)
   );

   assign bfly_in.k  = coef_ff[stage_ff];
   assign bfly_in.f  = f_ff;
   assign bfly_in.bd = delay_ff[stage_ff];

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign sample_ext = {{(VAL_W-SAMPLE_W){req_data.sample[SAMPLE_W-1]}}, req_data.sample};

   always_comb begin
      state_in     = state_ff;
      stages_in    = stages_ff;
      coef_in      = coef_ff;
      delay_in     = delay_ff;
      f_in         = f_ff;
      b_in         = b_ff;
      stage_in     = stage_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_we) begin
         stages_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.action == ACTION_LOAD) begin
                  if (int'(req_data.coef_index) < MAX_ORDER) begin
                     coef_in[IW'(req_data.coef_index)] = req_data.coef_value;
                  end
               end else begin
                  if (req_data.frame_start) begin
                     for (int i = 0; i < MAX_ORDER; i++) begin
                        delay_in[i] = '0;
                     end
                  end
                  f_in     = sample_ext;
                  b_in     = sample_ext;
                  stage_in = '0;
                  if (int'(stages_ff) > MAX_ORDER) begin
                     last_in = IW'(MAX_ORDER - 1);
                  end else begin
                     last_in = IW'(stages_ff - CFG_W'(1));
                  end
                  state_in = (stages_ff == '0) ? ST_DONE : ST_RUN;
               end
            end
         end
         ST_RUN: begin
            delay_in[stage_ff] = b_ff;
            f_in     = bfly_out.nf;
            b_in     = bfly_out.nb;
            stage_in = stage_ff + IW'(1);
            if (stage_ff == last_ff) begin
               if (out_free) begin
                  rsp_valid_in               = 1'b1;
                  rsp_data_in.forward_error  = bfly_out.nf;
                  rsp_data_in.backward_error = bfly_out.nb;
                  state_in                   = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.forward_error  = f_ff;
               rsp_data_in.backward_error = b_ff;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stages_ff    <= STAGES_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ORDER; i++) begin
            coef_ff[i]  <= '0;
            delay_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         stages_ff    <= stages_in;
         rsp_valid_ff <= rsp_valid_in;
         coef_ff      <= coef_in;
         delay_ff     <= delay_in;
      end
      f_ff        <= f_in;
      b_ff        <= b_in;
      stage_ff    <= stage_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/laf_checker.sv -----
// Port-level checks of the lattice analysis filter, bound to the top level.
// Depends on laf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module laf_checker
   import laf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic load_xact, filter_xact;

   assign load_xact   = req_valid && !req_stall && (req_data.action == ACTION_LOAD);
   assign filter_xact = req_valid && !req_stall && (req_data.action == ACTION_FILTER);

   // a filter transaction keeps the input closed while the stages run
   `ASSERT_NEXT_CYCLE(a_filter_busy, clock, reset, filter_xact, req_stall)
   // a load never blocks the following transaction
   `ASSERT_NEXT_CYCLE(a_load_open, clock, reset, load_xact, !req_stall)
   // a new result only appears after the filter was busy
   `ASSERT_SAME_CYCLE(a_rsp_after_work, clock, reset, $rose(rsp_valid), $past(req_stall))
   `ASSERT_NEXT_CYCLE(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT_CYCLE(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))

endmodule

bind lattice_analysis_filter_top laf_checker u_laf_checker (.*);

`default_nettype wire
